/* rtl/rrq_pkg.sv */
package rrq_pkg;

  localparam int DEPTH_DEF           = 16;
  localparam int PAYLOAD_BYTES_DEF   = 48;
  localparam logic [15:0] TRUNC_FLAG_MASK_DEF = 16'h0001;

  localparam int CFG_W   = 5;
  localparam int MODE_W  = 2;
  localparam int KIND_W  = 3;
  localparam int LEN_W   = 6;
  localparam int TYPE_W  = 16;
  localparam int FLAGS_W = 16;
  localparam int USER_W  = 64;
  localparam int PLEN_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int OCAP_W  = 16;
  localparam int LOST_W  = 32;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_HDR  = 2'd0,
    MODE_PUSH_DATA = 2'd1,
    MODE_POP       = 2'd2
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_OK   = 3'd0,
    KIND_PUSH_FULL = 3'd1,
    KIND_POP_EMPTY = 3'd2,
    KIND_POP_HDR   = 3'd3,
    KIND_POP_BYTE  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP_HDR,
    ST_POP_BYTE
  } state_t;

  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic [TYPE_W-1:0]  rtype;
    logic [FLAGS_W-1:0] flags;
    logic [USER_W-1:0]  user;
  } hdr_t;

endpackage

/* rtl/rrq_ram.sv */
module rrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/record_ring_queue.sv */
// channel | direction | handshake           | payload
// in      | sink      | in_valid/in_ready   | in_mode, in_type, in_flags, in_user,
//         |           |                     | in_payload_len, in_data_byte, in_out_capacity
// out     | source    | out_valid/out_ready | out_result_kind, out_last, out_type, out_flags,
//         |           |                     | out_user, out_rec_len, out_copy_len,
//         |           |                     | out_byte_out, out_lost_total
// cfg     | sink      | cfg_valid/cfg_ready | cfg_data (ring_capacity)
//
// push header, data byte and empty pop are taken from idle; data bytes one per cycle
// unless a result stalls; a pop that finds a record reads the header ram, then gives the
// header and one byte a cycle from the payload ram unless stalled, input held meanwhile
// a result waiting on out_ready holds off the input side
// reset is synchronous and needs no clearing pass; cfg is always ready
module record_ring_queue #(
  parameter int          DEPTH           = rrq_pkg::DEPTH_DEF,
  parameter int          PAYLOAD_BYTES   = rrq_pkg::PAYLOAD_BYTES_DEF,
  parameter logic [15:0] TRUNC_FLAG_MASK = rrq_pkg::TRUNC_FLAG_MASK_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rrq_pkg::MODE_W-1:0]   in_mode,
  input  logic [rrq_pkg::TYPE_W-1:0]   in_type,
  input  logic [rrq_pkg::FLAGS_W-1:0]  in_flags,
  input  logic [rrq_pkg::USER_W-1:0]   in_user,
  input  logic [rrq_pkg::PLEN_W-1:0]   in_payload_len,
  input  logic [rrq_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic [rrq_pkg::OCAP_W-1:0]   in_out_capacity,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rrq_pkg::KIND_W-1:0]   out_result_kind,
  output logic                         out_last,
  output logic [rrq_pkg::TYPE_W-1:0]   out_type,
  output logic [rrq_pkg::FLAGS_W-1:0]  out_flags,
  output logic [rrq_pkg::USER_W-1:0]   out_user,
  output logic [rrq_pkg::LEN_W-1:0]    out_rec_len,
  output logic [rrq_pkg::LEN_W-1:0]    out_copy_len,
  output logic [rrq_pkg::BYTE_W-1:0]   out_byte_out,
  output logic [rrq_pkg::LOST_W-1:0]   out_lost_total,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rrq_pkg::CFG_W-1:0]    cfg_data
);

  import rrq_pkg::*;

  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int PDEP  = DEPTH * PAYLOAD_BYTES;
  localparam int AW    = $clog2(PDEP);
  localparam int HDR_W = $bits(hdr_t);

  // control state
  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] cap_cfg_r, cap_cfg_nxt;
  logic [IW-1:0]    head_r, head_nxt;
  logic [IW-1:0]    tail_r, tail_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             filling_r, filling_nxt;
  logic [PLEN_W-1:0] pending_r, pending_nxt;
  logic [LEN_W-1:0] fill_off_r, fill_off_nxt;
  logic [LOST_W-1:0] lost_r, lost_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload registers
  logic [IW-1:0]     fill_slot_r, fill_slot_nxt;
  logic [AW-1:0]     fill_base_r, fill_base_nxt;
  logic [LEN_W-1:0]  fill_len_r, fill_len_nxt;
  logic [AW-1:0]     pop_base_r, pop_base_nxt;
  logic [LEN_W-1:0]  pop_csat_r, pop_csat_nxt;
  logic [LEN_W-1:0]  pop_idx_r, pop_idx_nxt;
  logic [LEN_W-1:0]  pop_copied_r, pop_copied_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic              out_last_r, out_last_nxt;
  logic [TYPE_W-1:0] out_type_r, out_type_nxt;
  logic [FLAGS_W-1:0] out_flags_r, out_flags_nxt;
  logic [USER_W-1:0] out_user_r, out_user_nxt;
  logic [LEN_W-1:0]  out_psize_r, out_psize_nxt;
  logic [LEN_W-1:0]  out_csize_r, out_csize_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic [LOST_W-1:0] out_lost_r, out_lost_nxt;

  // ram ports
  logic             hdr_we, hdr_re;
  logic [IW-1:0]    hdr_waddr, hdr_raddr;
  hdr_t             hdr_wr, hdr_rd;
  logic [HDR_W-1:0] hdr_rdata;
  logic             pay_we, pay_re;
  logic [AW-1:0]    pay_waddr, pay_raddr;
  logic [BYTE_W-1:0] pay_rdata;

  logic             out_free;
  logic [CW-1:0]    cap_c;
  logic             head_blocked;
  logic [LEN_W-1:0] copied_c;
  logic [FLAGS_W-1:0] flags_c;
  logic [LEN_W-1:0] len_c;

  function automatic logic [IW-1:0] nxt_idx(input logic [IW-1:0] i,
                                            input logic [CW-1:0] cap);
    logic [CW-1:0] n;
    n = CW'(i) + CW'(1);
    return (n >= cap) ? '0 : IW'(n);
  endfunction

  rrq_ram #(.WIDTH(HDR_W), .DEPTH(DEPTH)) u_hdr_ram (
    .clk   (clk),
    .we    (hdr_we),
    .waddr (hdr_waddr),
    .wdata (hdr_wr),
    .re    (hdr_re),
    .raddr (hdr_raddr),
    .rdata (hdr_rdata)
  );

  rrq_ram #(.WIDTH(BYTE_W), .DEPTH(PDEP)) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (pay_waddr),
    .wdata (in_data_byte),
    .re    (pay_re),
    .raddr (pay_raddr),
    .rdata (pay_rdata)
  );

  assign hdr_rd = hdr_t'(hdr_rdata);

  always_comb begin
    if (cap_cfg_r == '0) begin
      cap_c = CW'(1);
    end else if (32'(cap_cfg_r) > 32'(DEPTH)) begin
      cap_c = CW'(DEPTH);
    end else begin
      cap_c = CW'(cap_cfg_r);
    end
  end

  assign out_free     = !out_valid_r || out_ready;
  assign in_ready     = (state_r == ST_IDLE) && out_free;
  assign cfg_ready    = 1'b1;
  assign head_blocked = (count_r == '0) || (filling_r && (fill_slot_r == head_r));
  assign copied_c     = (pop_csat_r < hdr_rd.len) ? pop_csat_r : hdr_rd.len;

  always_comb begin
    if (in_payload_len > PLEN_W'(PAYLOAD_BYTES)) begin
      len_c   = LEN_W'(PAYLOAD_BYTES);
      flags_c = in_flags | TRUNC_FLAG_MASK;
    end else begin
      len_c   = in_payload_len[LEN_W-1:0];
      flags_c = in_flags;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cap_cfg_nxt    = cap_cfg_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    filling_nxt    = filling_r;
    pending_nxt    = pending_r;
    fill_off_nxt   = fill_off_r;
    lost_nxt       = lost_r;
    out_valid_nxt  = out_valid_r;
    fill_slot_nxt  = fill_slot_r;
    fill_base_nxt  = fill_base_r;
    fill_len_nxt   = fill_len_r;
    pop_base_nxt   = pop_base_r;
    pop_csat_nxt   = pop_csat_r;
    pop_idx_nxt    = pop_idx_r;
    pop_copied_nxt = pop_copied_r;
    out_kind_nxt   = out_kind_r;
    out_last_nxt   = out_last_r;
    out_type_nxt   = out_type_r;
    out_flags_nxt  = out_flags_r;
    out_user_nxt   = out_user_r;
    out_psize_nxt  = out_psize_r;
    out_csize_nxt  = out_csize_r;
    out_byte_nxt   = out_byte_r;
    out_lost_nxt   = out_lost_r;
    hdr_we         = 1'b0;
    hdr_waddr      = tail_r;
    hdr_wr         = '{len: len_c, rtype: in_type, flags: flags_c, user: in_user};
    hdr_re         = 1'b0;
    hdr_raddr      = head_r;
    pay_we         = 1'b0;
    pay_waddr      = fill_base_r + AW'(fill_off_r);
    pay_re         = 1'b0;
    pay_raddr      = pop_base_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          unique case (in_mode)
            MODE_PUSH_HDR: begin
              // any record still filling is published here
              filling_nxt   = 1'b0;
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              out_type_nxt  = '0;
              out_flags_nxt = '0;
              out_user_nxt  = '0;
              out_psize_nxt = '0;
              out_csize_nxt = '0;
              out_byte_nxt  = '0;
              pending_nxt   = in_payload_len;
              if (count_r >= cap_c) begin
                if (lost_r != '1) begin
                  lost_nxt = lost_r + LOST_W'(1);
                end
                out_kind_nxt = KIND_PUSH_FULL;
              end else begin
                hdr_we        = 1'b1;
                tail_nxt      = nxt_idx(tail_r, cap_c);
                count_nxt     = count_r + CW'(1);
                fill_slot_nxt = tail_r;
                fill_base_nxt = AW'(tail_r) * AW'(PAYLOAD_BYTES);
                fill_len_nxt  = len_c;
                fill_off_nxt  = '0;
                filling_nxt   = (in_payload_len != '0);
                out_kind_nxt  = KIND_PUSH_OK;
              end
              out_lost_nxt = lost_nxt;
            end
            MODE_PUSH_DATA: begin
              if (pending_r != '0) begin
                if (filling_r && (fill_off_r < fill_len_r)) begin
                  pay_we       = 1'b1;
                  fill_off_nxt = fill_off_r + LEN_W'(1);
                end
                pending_nxt = pending_r - PLEN_W'(1);
                if (pending_r == PLEN_W'(1)) begin
                  filling_nxt = 1'b0;
                end
              end
            end
            MODE_POP: begin
              if (head_blocked) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_POP_EMPTY;
                out_last_nxt  = 1'b1;
                out_type_nxt  = '0;
                out_flags_nxt = '0;
                out_user_nxt  = '0;
                out_psize_nxt = '0;
                out_csize_nxt = '0;
                out_byte_nxt  = '0;
                out_lost_nxt  = lost_r;
              end else begin
                hdr_re       = 1'b1;
                pop_base_nxt = AW'(head_r) * AW'(PAYLOAD_BYTES);
                pop_csat_nxt = (|in_out_capacity[OCAP_W-1:LEN_W]) ? '1
                                                                  : in_out_capacity[LEN_W-1:0];
                state_nxt    = ST_POP_HDR;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP_HDR: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_POP_HDR;
          out_last_nxt   = (copied_c == '0);
          out_type_nxt   = hdr_rd.rtype;
          out_flags_nxt  = hdr_rd.flags;
          out_user_nxt   = hdr_rd.user;
          out_psize_nxt  = hdr_rd.len;
          out_csize_nxt  = copied_c;
          out_byte_nxt   = '0;
          out_lost_nxt   = lost_r;
          pop_idx_nxt    = '0;
          pop_copied_nxt = copied_c;
          if (copied_c == '0) begin
            head_nxt  = nxt_idx(head_r, cap_c);
            count_nxt = count_r - CW'(1);
            state_nxt = ST_IDLE;
          end else begin
            pay_re    = 1'b1;
            pay_raddr = pop_base_r;
            state_nxt = ST_POP_BYTE;
          end
        end
      end
      ST_POP_BYTE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_POP_BYTE;
          out_last_nxt  = (pop_idx_r + LEN_W'(1) == pop_copied_r);
          out_type_nxt  = '0;
          out_flags_nxt = '0;
          out_user_nxt  = '0;
          out_psize_nxt = '0;
          out_csize_nxt = '0;
          out_byte_nxt  = pay_rdata;
          out_lost_nxt  = lost_r;
          if (pop_idx_r + LEN_W'(1) == pop_copied_r) begin
            head_nxt  = nxt_idx(head_r, cap_c);
            count_nxt = count_r - CW'(1);
            state_nxt = ST_IDLE;
          end else begin
            pay_re      = 1'b1;
            pay_raddr   = pop_base_r + AW'(pop_idx_r + LEN_W'(1));
            pop_idx_nxt = pop_idx_r + LEN_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // capacity write empties the queue, lost count kept
    if (cfg_valid && cfg_ready) begin
      cap_cfg_nxt  = cfg_data;
      head_nxt     = '0;
      tail_nxt     = '0;
      count_nxt    = '0;
      filling_nxt  = 1'b0;
      pending_nxt  = '0;
      fill_off_nxt = '0;
      fill_slot_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_cfg_r   <= CAP_RESET;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      filling_r   <= 1'b0;
      pending_r   <= '0;
      fill_off_r  <= '0;
      lost_r      <= '0;
      out_valid_r <= 1'b0;
      fill_slot_r <= '0;
    end else begin
      state_r     <= state_nxt;
      cap_cfg_r   <= cap_cfg_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      filling_r   <= filling_nxt;
      pending_r   <= pending_nxt;
      fill_off_r  <= fill_off_nxt;
      lost_r      <= lost_nxt;
      out_valid_r <= out_valid_nxt;
      fill_slot_r <= fill_slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_base_r  <= fill_base_nxt;
    fill_len_r   <= fill_len_nxt;
    pop_base_r   <= pop_base_nxt;
    pop_csat_r   <= pop_csat_nxt;
    pop_idx_r    <= pop_idx_nxt;
    pop_copied_r <= pop_copied_nxt;
    out_kind_r   <= out_kind_nxt;
    out_last_r   <= out_last_nxt;
    out_type_r   <= out_type_nxt;
    out_flags_r  <= out_flags_nxt;
    out_user_r   <= out_user_nxt;
    out_psize_r  <= out_psize_nxt;
    out_csize_r  <= out_csize_nxt;
    out_byte_r   <= out_byte_nxt;
    out_lost_r   <= out_lost_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_last         = out_last_r;
  assign out_type         = out_type_r;
  assign out_flags        = out_flags_r;
  assign out_user         = out_user_r;
  assign out_rec_len      = out_psize_r;
  assign out_copy_len     = out_csize_r;
  assign out_byte_out     = out_byte_r;
  assign out_lost_total   = out_lost_r;

endmodule

/* rtl/rrq_checker.sv */
module rrq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rrq_pkg::KIND_W-1:0]  out_result_kind,
  input logic                        out_last,
  input logic [rrq_pkg::LEN_W-1:0]   out_rec_len,
  input logic [rrq_pkg::LEN_W-1:0]   out_copy_len,
  input logic [rrq_pkg::BYTE_W-1:0]  out_byte_out,
  input logic [rrq_pkg::LOST_W-1:0]  out_lost_total
);

  import rrq_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind) &&
      $stable(out_last) && $stable(out_byte_out) && $stable(out_lost_total))
    else $error("result changed while stalled");

  // lost count never falls
  a_lost_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid || (out_lost_total >= $past(out_lost_total)))
    else $error("lost count went down");

  // copy length bounded by stored length
  a_copied_le: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_POP_HDR) |-> out_copy_len <= out_rec_len)
    else $error("copy length above record length");

  // single-result inputs are always last
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_PUSH_OK || out_result_kind == KIND_PUSH_FULL ||
      out_result_kind == KIND_POP_EMPTY) |-> out_last)
    else $error("single result not marked last");

  // no new input while a record is being delivered
  a_pop_holds_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last && (out_result_kind == KIND_POP_HDR ||
      out_result_kind == KIND_POP_BYTE) |-> !in_ready)
    else $error("input taken during pop delivery");

endmodule

bind record_ring_queue rrq_checker u_rrq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_kind  (out_result_kind),
  .out_last         (out_last),
  .out_rec_len      (out_rec_len),
  .out_copy_len     (out_copy_len),
  .out_byte_out     (out_byte_out),
  .out_lost_total   (out_lost_total)
);
